/* rtl/core/gga_pkg.sv */
// Shared types, constants and helper functions for the GGA sentence field parser.
`default_nettype none

package gga_pkg;

   // Sentence framing constants
   localparam int unsigned PrefixLen      = 6;
   localparam logic [7:0]  CharComma      = 8'h2C;
   localparam logic [7:0]  CharZero       = 8'h30;
   localparam logic [7:0]  CharNine       = 8'h39;
   localparam logic [3:0]  CommasRequired = 4'd14;
   localparam logic [3:0]  CommaMax       = 4'd15;
   localparam logic [3:0]  OffsetMax      = 4'd15;

   // Field numbers, counted by commas seen
   localparam logic [3:0]  FieldTime      = 4'd1;
   localparam logic [3:0]  FieldLat       = 4'd2;
   localparam logic [3:0]  FieldLatHemi   = 4'd3;
   localparam logic [3:0]  FieldLon       = 4'd4;
   localparam logic [3:0]  FieldLonHemi   = 4'd5;

   localparam int unsigned TimeDigits = 6;
   localparam int unsigned LatDigits  = 6;
   localparam int unsigned LonDigits  = 7;

   // Result payload widths
   localparam int unsigned RspDataWidth = 96;

   // Line state captured at end of line
   typedef struct packed {
      logic                            line_valid;
      logic [TimeDigits-1:0][3:0]      time_digits;
      logic [LatDigits-1:0][3:0]       lat_digits;
      logic [LonDigits-1:0][3:0]       lon_digits;
      logic [7:0]                      lat_letter;
      logic [7:0]                      lon_letter;
   } line_snap_type;

   // Expected prefix character at a given line position
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = 8'h24; // '$'
         3'd1:    c = 8'h47; // 'G'
         3'd2:    c = 8'h50; // 'P'
         3'd3:    c = 8'h47; // 'G'
         3'd4:    c = 8'h47; // 'G'
         3'd5:    c = 8'h41; // 'A'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Digit value of a character, zero for anything that is not a decimal digit
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = c - CharZero;
      return (c >= CharZero && c <= CharNine) ? d[3:0] : 4'd0;
   endfunction

   // Two decimal digits to a binary value, 0..99
   function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
      logic [6:0] hi10;
      hi10 = ({3'd0, hi} << 3) + ({3'd0, hi} << 1);
      return hi10 + {3'd0, lo};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gga_sentence_field_parser_unit.sv */
// Top level of the GGA sentence field parser.
//
// Request channel (req_*): one text character per request in req_tdata, with
// req_tlast high on the last character of a sentence. Response channel
// (rsp_*): one response per sentence, emitted after its last character.
// rsp_tuser is high when the line began with "$GPGGA" and held exactly 14
// commas; otherwise every rsp_tdata field is zero.
//
// Throughput: one character per cycle while req_tready is high. Each
// character updates the line tracker in the cycle it is accepted. After the
// last character, the response passes through the snapshot register, then
// the output register.
//
// Reset clears the line state and the snapshot and output valid flags.
// When the receiver stalls, the response holds in the output register and
// one more finished sentence can wait in the snapshot stage; once that stage
// is full and the output register cannot take it, req_tready stays low for
// every character until the receiver drains the output register.
`default_nettype none

module gga_sentence_field_parser_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] char_in
   input  wire logic         req_tlast,   // end_of_line
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [6:0] hours, [13:7] minutes, [20:14] seconds, [27:21] lat_degrees,
   // [34:28] lat_minutes, [47:35] lat_sec_hundredths, [55:48] lat_hemisphere,
   // [65:56] lon_degrees, [72:66] lon_minutes, [85:73] lon_sec_hundredths,
   // [93:86] lon_hemisphere, [95:94] zero
   output logic [gga_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic              rsp_tuser    // sentence_valid
);

   logic                   snap_valid;
   logic                   snap_ready;
   gga_pkg::line_snap_type snap;

   gga_line_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   gga_result_format u_format (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* rtl/core/gga_line_tracker.sv */
// Per-character line state update and end-of-line snapshot register.
`default_nettype none

module gga_line_tracker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] char_in
   input  wire logic                   req_tlast,   // end_of_line
   output logic                        snap_valid,
   input  wire logic                   snap_ready,
   output gga_pkg::line_snap_type      snap
);

   logic [2:0]  pos_ff, pos_in;
   logic        pok_ff, pok_in;
   logic [3:0]  comma_ff, comma_in;
   logic [3:0]  off_ff, off_in;
   logic [gga_pkg::TimeDigits-1:0][3:0] time_ff, time_in;
   logic [gga_pkg::LatDigits-1:0][3:0]  lat_ff, lat_in;
   logic [gga_pkg::LonDigits-1:0][3:0]  lon_ff, lon_in;
   logic [7:0]  lat_let_ff, lat_let_in;
   logic [7:0]  lon_let_ff, lon_let_in;

   logic                   snap_valid_ff, snap_valid_in;
   gga_pkg::line_snap_type snap_ff, snap_in;

   logic       accept;
   logic [3:0] dig;
   logic       is_comma;

   assign req_tready = !snap_valid_ff || snap_ready;
   assign accept     = req_tvalid && req_tready;
   assign dig        = gga_pkg::digit_value(req_tdata);
   assign is_comma   = (req_tdata == gga_pkg::CharComma);

   // Advance the line state by one character
   always_comb begin
      pos_in     = pos_ff;
      pok_in     = pok_ff;
      comma_in   = comma_ff;
      off_in     = off_ff;
      time_in    = time_ff;
      lat_in     = lat_ff;
      lon_in     = lon_ff;
      lat_let_in = lat_let_ff;
      lon_let_in = lon_let_ff;

      if (pos_ff < 3'(gga_pkg::PrefixLen)) begin
         if (req_tdata != gga_pkg::prefix_char(pos_ff)) pok_in = 1'b0;
         pos_in = pos_ff + 3'd1;
      end

      if (is_comma) begin
         if (comma_ff < gga_pkg::CommaMax) comma_in = comma_ff + 4'd1;
         off_in = 4'd0;
      end else begin
         // Time: offsets 0..5
         for (int i = 0; i < gga_pkg::TimeDigits; i++) begin
            if (comma_ff == gga_pkg::FieldTime && off_ff == 4'(i)) time_in[i] = dig;
         end
         // Latitude: offsets 0..3 and 5..6, dot skipped
         for (int i = 0; i < gga_pkg::LatDigits; i++) begin
            if (comma_ff == gga_pkg::FieldLat &&
                off_ff == ((i < 4) ? 4'(i) : 4'(i + 1))) lat_in[i] = dig;
         end
         // Longitude: offsets 0..4 and 6..7, dot skipped
         for (int i = 0; i < gga_pkg::LonDigits; i++) begin
            if (comma_ff == gga_pkg::FieldLon &&
                off_ff == ((i < 5) ? 4'(i) : 4'(i + 1))) lon_in[i] = dig;
         end
         if (comma_ff == gga_pkg::FieldLatHemi && off_ff == 4'd0) lat_let_in = req_tdata;
         if (comma_ff == gga_pkg::FieldLonHemi && off_ff == 4'd0) lon_let_in = req_tdata;
         if (off_ff < gga_pkg::OffsetMax) off_in = off_ff + 4'd1;
      end
   end

   // Build the snapshot and drive the stage handshake
   always_comb begin
      snap_in.line_valid  = pok_in && (pos_in == 3'(gga_pkg::PrefixLen)) &&
                            (comma_in == gga_pkg::CommasRequired);
      snap_in.time_digits = time_in;
      snap_in.lat_digits  = lat_in;
      snap_in.lon_digits  = lon_in;
      snap_in.lat_letter  = lat_let_in;
      snap_in.lon_letter  = lon_let_in;

      snap_valid_in = snap_valid_ff;
      if (accept && req_tlast) snap_valid_in = 1'b1;
      else if (snap_ready)     snap_valid_in = 1'b0;
   end

   // Hold line state; clear it after the last character of a line
   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         pos_ff     <= '0;
         pok_ff     <= 1'b1;
         comma_ff   <= '0;
         off_ff     <= '0;
         time_ff    <= '0;
         lat_ff     <= '0;
         lon_ff     <= '0;
         lat_let_ff <= '0;
         lon_let_ff <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         pok_ff     <= pok_in;
         comma_ff   <= comma_in;
         off_ff     <= off_in;
         time_ff    <= time_in;
         lat_ff     <= lat_in;
         lon_ff     <= lon_in;
         lat_let_ff <= lat_let_in;
         lon_let_ff <= lon_let_in;
      end
   end

   // Snapshot register
   always_ff @(posedge clock) begin
      if (reset) snap_valid_ff <= 1'b0;
      else       snap_valid_ff <= snap_valid_in;
      if (accept && req_tlast) snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

`default_nettype wire

/* rtl/core/gga_result_format.sv */
// Decimal-to-binary field formatting and the result output register.
`default_nettype none

module gga_result_format (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          snap_valid,
   output logic                               snap_ready,
   input  wire gga_pkg::line_snap_type        snap,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [gga_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                               rsp_tuser
);

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gga_pkg::RspDataWidth-1:0]  rsp_data_ff, rsp_data_in;
   logic                              rsp_user_ff;
   logic                              load;

   logic [6:0]  hours, minutes, seconds, lat_deg, lat_min, lat_cm, lon_min, lon_cm, lon_lo;
   logic [12:0] lat_sec, lon_sec;
   logic [9:0]  lon_deg, lon_hi;
   logic [6:0]  lat_cm_raw, lon_cm_raw;

   assign snap_ready = !rsp_valid_ff || rsp_tready;
   assign load       = snap_valid && snap_ready;

   // Convert digit pairs; scale centiminutes by 60 as 64x - 4x
   always_comb begin
      hours      = gga_pkg::two_digits(snap.time_digits[0], snap.time_digits[1]);
      minutes    = gga_pkg::two_digits(snap.time_digits[2], snap.time_digits[3]);
      seconds    = gga_pkg::two_digits(snap.time_digits[4], snap.time_digits[5]);
      lat_deg    = gga_pkg::two_digits(snap.lat_digits[0], snap.lat_digits[1]);
      lat_min    = gga_pkg::two_digits(snap.lat_digits[2], snap.lat_digits[3]);
      lat_cm_raw = gga_pkg::two_digits(snap.lat_digits[4], snap.lat_digits[5]);
      lon_lo     = gga_pkg::two_digits(snap.lon_digits[1], snap.lon_digits[2]);
      lon_min    = gga_pkg::two_digits(snap.lon_digits[3], snap.lon_digits[4]);
      lon_cm_raw = gga_pkg::two_digits(snap.lon_digits[5], snap.lon_digits[6]);
      lat_cm     = lat_cm_raw;
      lon_cm     = lon_cm_raw;
      lat_sec    = ({6'd0, lat_cm} << 6) - ({6'd0, lat_cm} << 2);
      lon_sec    = ({6'd0, lon_cm} << 6) - ({6'd0, lon_cm} << 2);
      lon_hi     = ({6'd0, snap.lon_digits[0]} << 6) + ({6'd0, snap.lon_digits[0]} << 5)
                 + ({6'd0, snap.lon_digits[0]} << 2);
      lon_deg    = lon_hi + {3'd0, lon_lo};

      rsp_data_in = '0;
      if (snap.line_valid) begin
         rsp_data_in[6:0]   = hours;
         rsp_data_in[13:7]  = minutes;
         rsp_data_in[20:14] = seconds;
         rsp_data_in[27:21] = lat_deg;
         rsp_data_in[34:28] = lat_min;
         rsp_data_in[47:35] = lat_sec;
         rsp_data_in[55:48] = snap.lat_letter;
         rsp_data_in[65:56] = lon_deg;
         rsp_data_in[72:66] = lon_min;
         rsp_data_in[85:73] = lon_sec;
         rsp_data_in[93:86] = snap.lon_letter;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // Output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= snap.line_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* verif/tb_gga_sentence_field_parser_unit.sv */
// Testbench for the GGA sentence field parser: random sentences checked against a line decoder.
module tb_gga_sentence_field_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ClockPeriod = 4;
   localparam int          CycleLimit  = 200000;
   localparam int          CharTarget  = 1150;
   localparam logic [47:0] GgaTag      = "$GPGGA";

   // One decoded sentence as the response channel carries it
   typedef struct packed {
      bit        valid;
      bit [6:0]  hours;
      bit [6:0]  minutes;
      bit [6:0]  seconds;
      bit [6:0]  lat_deg;
      bit [6:0]  lat_min;
      bit [12:0] lat_sec;
      bit [7:0]  lat_hemi;
      bit [9:0]  lon_deg;
      bit [6:0]  lon_min;
      bit [12:0] lon_sec;
      bit [7:0]  lon_hemi;
   } gga_fix_type;

   // Line decoder plus queue of decoded sentences waiting on the response side
   class gga_line_scoreboard;
      bit [2:0]    line_pos;
      bit          tag_match;
      bit [3:0]    comma_cnt;
      bit [3:0]    field_pos;
      bit [3:0]    time_dig [6];
      bit [3:0]    lat_dig [6];
      bit [3:0]    lon_dig [7];
      bit [7:0]    lat_hemi_ch;
      bit [7:0]    lon_hemi_ch;
      gga_fix_type fixes_due [$];
      int unsigned mismatches;
      int unsigned lines_seen;
      int unsigned valid_lines;
      int unsigned responses_seen;

      function new();
         restart_line();
      endfunction

      function void restart_line();
         line_pos    = 0;
         tag_match   = 1;
         comma_cnt   = 0;
         field_pos   = 0;
         lat_hemi_ch = 0;
         lon_hemi_ch = 0;
         foreach (time_dig[i]) time_dig[i] = 0;
         foreach (lat_dig[i]) lat_dig[i] = 0;
         foreach (lon_dig[i]) lon_dig[i] = 0;
      endfunction

      // Update the line with one accepted character; decode the line on its last one
      function void note_char(bit [7:0] ch, bit eol);
         bit [3:0] dig;
         gga_fix_type fix;
         dig = (ch >= gga_pkg::CharZero && ch <= gga_pkg::CharNine) ?
               4'(ch - gga_pkg::CharZero) : 4'd0;
         if (line_pos < gga_pkg::PrefixLen) begin
            if (ch != GgaTag[8*(5-line_pos) +: 8]) tag_match = 0;
            line_pos++;
         end
         if (ch == gga_pkg::CharComma) begin
            if (comma_cnt != gga_pkg::CommaMax) comma_cnt++;
            field_pos = 0;
         end else begin
            // capture digits and letters by field; the dot position is skipped
            case (comma_cnt)
               gga_pkg::FieldTime: if (field_pos < 6) time_dig[field_pos] = dig;
               gga_pkg::FieldLat: begin
                  if (field_pos < 4) lat_dig[field_pos] = dig;
                  else if (field_pos == 5 || field_pos == 6) lat_dig[field_pos-1] = dig;
               end
               gga_pkg::FieldLatHemi: if (field_pos == 0) lat_hemi_ch = ch;
               gga_pkg::FieldLon: begin
                  if (field_pos < 5) lon_dig[field_pos] = dig;
                  else if (field_pos == 6 || field_pos == 7) lon_dig[field_pos-1] = dig;
               end
               gga_pkg::FieldLonHemi: if (field_pos == 0) lon_hemi_ch = ch;
               default: ;
            endcase
            if (field_pos != gga_pkg::OffsetMax) field_pos++;
         end
         if (!eol) return;
         fix = '0;
         if (tag_match && line_pos == gga_pkg::PrefixLen &&
             comma_cnt == gga_pkg::CommasRequired) begin
            fix.valid    = 1;
            fix.hours    = 7'(time_dig[0] * 10 + time_dig[1]);
            fix.minutes  = 7'(time_dig[2] * 10 + time_dig[3]);
            fix.seconds  = 7'(time_dig[4] * 10 + time_dig[5]);
            fix.lat_deg  = 7'(lat_dig[0] * 10 + lat_dig[1]);
            fix.lat_min  = 7'(lat_dig[2] * 10 + lat_dig[3]);
            fix.lat_sec  = 13'((lat_dig[4] * 10 + lat_dig[5]) * 60);
            fix.lat_hemi = lat_hemi_ch;
            fix.lon_deg  = 10'(lon_dig[0] * 100 + lon_dig[1] * 10 + lon_dig[2]);
            fix.lon_min  = 7'(lon_dig[3] * 10 + lon_dig[4]);
            fix.lon_sec  = 13'((lon_dig[5] * 10 + lon_dig[6]) * 60);
            fix.lon_hemi = lon_hemi_ch;
            valid_lines++;
         end
         fixes_due.push_back(fix);
         lines_seen++;
         restart_line();
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one accepted response with the oldest decoded sentence
      function void check_response(logic user, logic [gga_pkg::RspDataWidth-1:0] data);
         gga_fix_type want;
         responses_seen++;
         if (fixes_due.size() == 0) begin
            $error("response with no sentence pending");
            mismatches++;
            return;
         end
         want = fixes_due.pop_front();
         compare_field("sentence_valid", want.valid, user);
         compare_field("hours", want.hours, data[6:0]);
         compare_field("minutes", want.minutes, data[13:7]);
         compare_field("seconds", want.seconds, data[20:14]);
         compare_field("lat_degrees", want.lat_deg, data[27:21]);
         compare_field("lat_minutes", want.lat_min, data[34:28]);
         compare_field("lat_sec_hundredths", want.lat_sec, data[47:35]);
         compare_field("lat_hemisphere", want.lat_hemi, data[55:48]);
         compare_field("lon_degrees", want.lon_deg, data[65:56]);
         compare_field("lon_minutes", want.lon_min, data[72:66]);
         compare_field("lon_sec_hundredths", want.lon_sec, data[85:73]);
         compare_field("lon_hemisphere", want.lon_hemi, data[93:86]);
      endfunction
   endclass

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_tvalid = 0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;   // [7:0] char_in
   logic                    req_tlast = 0;    // end_of_line
   logic                    rsp_tvalid;
   logic                    rsp_tready = 0;
   logic [gga_pkg::RspDataWidth-1:0] rsp_tdata;  // hours .. lon_hemisphere, see block ports
   logic                    rsp_tuser;        // sentence_valid

   gga_line_scoreboard sb = new();
   bit [7:0]    line_q [$];
   int unsigned chars_sent;
   int unsigned cycle_count;
   int          burst_left;
   int          stall_mode;
   int          stall_left;

   gga_sentence_field_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout with %0d sentences outstanding", sb.fixes_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
      end
   end

   // Stall the response side in phases: always ready, coin flip, mostly stalled
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Field text: mostly digits, sometimes any byte but a comma
   function automatic bit [7:0] field_byte(bit nines);
      bit [7:0] ch;
      if (nines) return gga_pkg::CharNine;
      if ($urandom_range(0, 99) < 92) return 8'(gga_pkg::CharZero + $urandom_range(0, 9));
      do ch = 8'($urandom_range(0, 255)); while (ch == gga_pkg::CharComma);
      return ch;
   endfunction

   function automatic void add_chars(int n, bit nines);
      for (int i = 0; i < n; i++) line_q.push_back(field_byte(nines));
   endfunction

   function automatic void add_hemi(bit [7:0] a, bit [7:0] b);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) line_q.push_back(a);
      else if (roll < 90) line_q.push_back(b);
      else if (roll < 95) line_q.push_back(field_byte(0));
   endfunction

   // Build a sentence, mostly well formed with random content
   function automatic void build_sentence();
      int commas;
      int tag_len;
      bit nines;
      line_q.delete();
      nines   = ($urandom_range(0, 9) == 0);
      commas  = ($urandom_range(0, 99) < 80) ? 14 : $urandom_range(0, 19);
      tag_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 5) : 6;
      for (int k = 0; k < tag_len; k++) line_q.push_back(GgaTag[8*(5-k) +: 8]);
      if (tag_len > 0 && $urandom_range(0, 14) == 0)
         line_q[$urandom_range(0, tag_len - 1)] = 8'($urandom_range(0, 255));
      for (int k = 1; k <= commas; k++) begin
         line_q.push_back(gga_pkg::CharComma);
         case (k)
            gga_pkg::FieldTime: begin
               if ($urandom_range(0, 99) < 80) begin
                  add_chars(6, nines);
                  if ($urandom_range(0, 1)) begin
                     line_q.push_back(".");
                     add_chars(2, nines);
                  end
               end else begin
                  add_chars($urandom_range(0, 20), nines);
               end
            end
            gga_pkg::FieldLat: begin
               if ($urandom_range(0, 99) < 80) begin
                  add_chars(4, nines);
                  line_q.push_back(".");
                  add_chars($urandom_range(2, 4), nines);
               end else begin
                  add_chars($urandom_range(0, 18), nines);
               end
            end
            gga_pkg::FieldLatHemi: add_hemi("N", "S");
            gga_pkg::FieldLon: begin
               if ($urandom_range(0, 99) < 80) begin
                  add_chars(5, nines);
                  line_q.push_back(".");
                  add_chars($urandom_range(2, 4), nines);
               end else begin
                  add_chars($urandom_range(0, 18), nines);
               end
            end
            gga_pkg::FieldLonHemi: add_hemi("E", "W");
            default: add_chars($urandom_range(0, 3), 0);
         endcase
      end
      if (line_q.size() == 0) line_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Noise: raw bytes of any value, commas included
   function automatic void build_noise();
      line_q.delete();
      repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void load_text(string s);
      line_q.delete();
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   // Offer one character; open a new burst with a random gap when the old one runs out
   task automatic send_char(bit [7:0] ch, bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: valid line with all fields empty ending on its last comma,
      // a short line, and a lone all-ones byte
      load_text("$GPGGA,,,,,,,,,,,,,,");
      send_line();
      load_text("$GP");
      send_line();
      line_q.delete();
      line_q.push_back(8'hFF);
      send_line();

      // Random sentences with some noise lines
      while (chars_sent < CharTarget) begin
         if ($urandom_range(0, 99) < 85) build_sentence();
         else build_noise();
         send_line();
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Drain outstanding responses, then allow for stray ones
      while (sb.fixes_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Drove %0d characters in %0d sentences; %0d decoded as valid GGA fixes.",
               chars_sent, sb.lines_seen, sb.valid_lines);
      $display("Checked %0d responses, %0d field mismatches.", sb.responses_seen,
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* gga_sentence_field_parser_unit.f */
rtl/core/gga_pkg.sv
rtl/core/gga_line_tracker.sv
rtl/core/gga_result_format.sv
rtl/core/gga_sentence_field_parser_unit.sv
verif/tb_gga_sentence_field_parser_unit.sv
